// ----- hw/rtl/t6p_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// t6p_pkg
// Shared types and codes for the 6in4 tunnel header parser.
// ----------------------------------------------------------------------------
package t6p_pkg;

    localparam int unsigned MAX_FRAME_BYTES_DEFAULT = 65535;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned LINK_W   = 2;
    // status, payload_offset, payload_length packed, rounded up to whole bytes
    localparam int unsigned RES_BITS = STATUS_W + 2 * POS_W;
    localparam int unsigned M_DATA_W = ((RES_BITS + 7) / 8) * 8;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TRUNC   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LINK    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ETYPE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT4    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT6    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_SLLTYPE = 3'd6;
    localparam logic [STATUS_W-1:0] ST_NOT6IN4 = 3'd7;

    // Capture link kinds
    localparam logic [LINK_W-1:0] LINK_ETH  = 2'd0;
    localparam logic [LINK_W-1:0] LINK_RAW  = 2'd1;
    localparam logic [LINK_W-1:0] LINK_SLL  = 2'd2;
    localparam logic [LINK_W-1:0] LINK_UNKN = 2'd3;

    typedef struct packed {
        logic                last_byte;
        logic [DATA_W-1:0]   data_byte;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]    payload_length;
        logic [POS_W-1:0]    payload_offset;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage : t6p_pkg
`default_nettype wire

// ----- hw/rtl/t6p_in_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// t6p_in_stage
// Input register: captures one byte transaction and holds it until the
// parser takes it.
// ----------------------------------------------------------------------------
module t6p_in_stage
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire t6p_pkg::item_t in_item,
    input  wire logic          take,
    output logic               item_valid,
    output t6p_pkg::item_t     item
);
    import t6p_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Refill in the same cycle the held item is taken
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule : t6p_in_stage
`default_nettype wire

// ----- hw/rtl/t6p_parse.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// t6p_parse
// Per-byte header walker: link header, VLAN tags, outer IPv4/IPv6, and the
// verdict on the last byte of each frame.
// ----------------------------------------------------------------------------
module t6p_parse
#(
    parameter int unsigned MAX_FRAME_BYTES = t6p_pkg::MAX_FRAME_BYTES_DEFAULT
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [t6p_pkg::LINK_W-1:0]   cfg_link_kind,
    input  wire logic                         item_valid,
    input  wire t6p_pkg::item_t               item,
    input  wire logic                         out_free,
    output logic                              take,
    output logic                              res_valid,
    output t6p_pkg::result_t                  res
);
    import t6p_pkg::*;

    typedef enum logic [2:0] {
        LYR_START,
        LYR_ETH,
        LYR_VLAN,
        LYR_SLL,
        LYR_IPV4,
        LYR_IPV6,
        LYR_DONE,
        LYR_PAYLOAD
    } layer_t;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [15:0] ETYPE_VLAN = 16'h8100;
    localparam logic [7:0]  TUNNEL_PROTO = 8'd41;
    localparam logic [POS_W-1:0] COUNT_MAX = POS_W'(MAX_FRAME_BYTES);

    logic [LINK_W-1:0] link_kind_reg;
    layer_t            layer_reg,   layer_next;
    logic [5:0]        idx_reg,     idx_next;
    logic [POS_W-1:0]  count_reg,   count_next;
    logic [7:0]        shift_reg,   shift_next;
    logic [5:0]        hdr_reg,     hdr_next;
    logic [2:0]        verdict_reg, verdict_next;
    logic [POS_W-1:0]  inner_reg,   inner_next;

    logic [7:0]        b;
    logic [15:0]       etype;
    logic [POS_W-1:0]  base4;
    logic [POS_W:0]    sum4;
    layer_t            layer_e;
    logic [5:0]        idx_e;
    logic [2:0]        verdict_e;
    logic              advance;
    logic              vlan_ok;
    result_t           res_c;

    assign take      = item_valid && (!item.last_byte || out_free);
    assign res_valid = take && item.last_byte;
    assign b         = item.data_byte;
    assign etype     = {shift_reg, b};

    always_comb
    begin
        // Saturating frame byte count
        count_next = (count_reg < COUNT_MAX) ? count_reg + 1'b1 : count_reg;

        layer_e   = layer_reg;
        idx_e     = idx_reg;
        verdict_e = verdict_reg;
        if (layer_reg == LYR_START)
        begin
            idx_e     = 6'd0;
            verdict_e = ST_OK;
            unique case (link_kind_reg)
                LINK_ETH:  layer_e = LYR_ETH;
                LINK_RAW:  layer_e = LYR_IPV4;
                LINK_SLL:  layer_e = LYR_SLL;
                LINK_UNKN:
                begin
                    layer_e   = LYR_DONE;
                    verdict_e = ST_LINK;
                end
                default:   layer_e = LYR_DONE;
            endcase
        end

        layer_next   = layer_e;
        idx_next     = idx_e;
        verdict_next = verdict_e;
        shift_next   = shift_reg;
        hdr_next     = hdr_reg;
        inner_next   = inner_reg;
        advance      = 1'b1;
        vlan_ok      = 1'b0;

        base4 = (count_next >= POS_W'(20)) ? count_next - POS_W'(20) : '0;
        sum4  = {1'b0, base4} + (POS_W+1)'(hdr_reg);

        unique case (layer_e)
            LYR_ETH, LYR_VLAN:
            begin
                if (idx_e == ((layer_e == LYR_ETH) ? 6'd12 : 6'd2))
                begin
                    shift_next = b;
                end
                if (idx_e == ((layer_e == LYR_ETH) ? 6'd13 : 6'd3))
                begin
                    advance = 1'b0;
                    vlan_ok = 1'b1;
                end
            end
            LYR_SLL:
            begin
                if (idx_e == 6'd0 || idx_e == 6'd14)
                begin
                    shift_next = b;
                end
                if (idx_e == 6'd1 && etype > 16'd4)
                begin
                    verdict_next = ST_SLLTYPE;
                end
                if (idx_e == 6'd15)
                begin
                    advance = 1'b0;
                    if (verdict_e != ST_OK)
                    begin
                        layer_next = LYR_DONE;
                    end
                end
            end
            LYR_IPV4:
            begin
                if (idx_e == 6'd0)
                begin
                    hdr_next = {b[3:0], 2'b00};
                    if (b[7:4] != 4'd4)
                    begin
                        verdict_next = ST_NOT4;
                    end
                end
                if (idx_e == 6'd9 && b != TUNNEL_PROTO && verdict_e == ST_OK)
                begin
                    verdict_next = ST_NOT6IN4;
                end
                if (idx_e == 6'd19)
                begin
                    advance = 1'b0;
                    if (verdict_e != ST_OK)
                    begin
                        layer_next = LYR_DONE;
                    end
                    else
                    begin
                        // Clamp offsets that run past 16 bits
                        inner_next = sum4[POS_W] ? '1 : sum4[POS_W-1:0];
                        layer_next = LYR_PAYLOAD;
                    end
                end
            end
            LYR_IPV6:
            begin
                if (idx_e == 6'd0 && b[7:4] != 4'd6)
                begin
                    verdict_next = ST_NOT6;
                end
                if (idx_e == 6'd6 && b != TUNNEL_PROTO && verdict_e == ST_OK)
                begin
                    verdict_next = ST_NOT6IN4;
                end
                if (idx_e == 6'd39)
                begin
                    advance = 1'b0;
                    if (verdict_e != ST_OK)
                    begin
                        layer_next = LYR_DONE;
                    end
                    else
                    begin
                        inner_next = count_next;
                        layer_next = LYR_PAYLOAD;
                    end
                end
            end
            LYR_START, LYR_DONE, LYR_PAYLOAD:
            begin
                advance = 1'b0;
            end
            default:
            begin
                advance = 1'b0;
            end
        endcase

        // Ethertype dispatch at the end of a link header or VLAN tag
        if ((layer_e == LYR_ETH && idx_e == 6'd13) || (layer_e == LYR_VLAN && idx_e == 6'd3)
            || (layer_e == LYR_SLL && idx_e == 6'd15 && verdict_e == ST_OK))
        begin
            priority if (etype == ETYPE_IPV4)
            begin
                layer_next   = LYR_IPV4;
                idx_next     = 6'd0;
                verdict_next = ST_OK;
            end
            else if (etype == ETYPE_IPV6)
            begin
                layer_next   = LYR_IPV6;
                idx_next     = 6'd0;
                verdict_next = ST_OK;
            end
            else if (etype == ETYPE_VLAN && vlan_ok)
            begin
                layer_next   = LYR_VLAN;
                idx_next     = 6'd0;
                verdict_next = ST_OK;
            end
            else
            begin
                layer_next   = LYR_DONE;
                verdict_next = ST_ETYPE;
            end
        end

        if (advance)
        begin
            idx_next = idx_e + 1'b1;
        end

        // Verdict for the last byte
        res_c.status         = ST_TRUNC;
        res_c.payload_offset = '0;
        res_c.payload_length = '0;
        if (layer_next == LYR_DONE)
        begin
            res_c.status = verdict_next;
        end
        else if (layer_next == LYR_PAYLOAD && count_next >= inner_next)
        begin
            res_c.status         = ST_OK;
            res_c.payload_offset = inner_next;
            res_c.payload_length = count_next - inner_next;
        end

        // Clear for the next frame
        if (item.last_byte)
        begin
            layer_next   = LYR_START;
            idx_next     = 6'd0;
            count_next   = '0;
            shift_next   = '0;
            hdr_next     = '0;
            verdict_next = ST_OK;
            inner_next   = '0;
        end
    end

    assign res = res_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_kind_reg <= LINK_ETH;
            layer_reg     <= LYR_START;
            idx_reg       <= '0;
            count_reg     <= '0;
            shift_reg     <= '0;
            hdr_reg       <= '0;
            verdict_reg   <= ST_OK;
            inner_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                link_kind_reg <= cfg_link_kind;
            end
            if (take)
            begin
                layer_reg   <= layer_next;
                idx_reg     <= idx_next;
                count_reg   <= count_next;
                shift_reg   <= shift_next;
                hdr_reg     <= hdr_next;
                verdict_reg <= verdict_next;
                inner_reg   <= inner_next;
            end
        end
    end

endmodule : t6p_parse
`default_nettype wire

// ----- hw/rtl/t6p_out_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// t6p_out_stage
// Result register: holds one verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
module t6p_out_stage
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire t6p_pkg::result_t res,
    output logic                  out_free,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output t6p_pkg::result_t      out_res
);
    import t6p_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule : t6p_out_stage
`default_nettype wire

// ----- hw/rtl/tunnel_6in4_header_parser_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tunnel_6in4_header_parser_top
// Byte-stream parser for link, VLAN and outer IP headers of 6in4 frames.
// ----------------------------------------------------------------------------
// Frame bytes enter one transaction per cycle on the s_ side, tlast marking
// the final byte. Each byte is registered, then the parser state is updated,
// so the block sustains one byte per cycle. One result transaction leaves on
// the m_ side per frame, from the result register loaded as the parser takes
// its last byte. Input stalls only when a last byte finds the result register
// still occupied. The user must write link_kind on cfg_ only while the block
// is idle (the block does not enforce it); sampled at each frame's first byte.
// ----------------------------------------------------------------------------
module tunnel_6in4_header_parser_top
#(
    parameter int unsigned MAX_FRAME_BYTES = t6p_pkg::MAX_FRAME_BYTES_DEFAULT
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [t6p_pkg::LINK_W-1:0]      cfg_data,     // link_kind
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [t6p_pkg::DATA_W-1:0]      s_tdata,      // data_byte
    input  wire logic                            s_tlast,      // last_byte
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // status [2:0], payload_offset [18:3], payload_length [34:19], zero pad
    output logic [t6p_pkg::M_DATA_W-1:0]         m_tdata
);
    import t6p_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    logic    out_free;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign cfg_ready = 1'b1;

    assign in_item.data_byte = s_tdata;
    assign in_item.last_byte = s_tlast;

    t6p_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    t6p_parse #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parse
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_link_kind (cfg_data),
        .item_valid    (item_valid),
        .item          (item),
        .out_free      (out_free),
        .take          (take),
        .res_valid     (res_valid),
        .res           (res)
    );

    t6p_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = M_DATA_W'(out_res);

    // A verdict only loads into a free result register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free)
        else $error("result register overwritten");

    // Backpressure only comes from a held input item
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> item_valid && item.last_byte && !out_free)
        else $error("input stalled without cause");

    // Failed frames carry no offset or length
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_res.status != ST_OK)
            |-> (out_res.payload_offset == '0 && out_res.payload_length == '0))
        else $error("nonzero payload fields on failed frame");

endmodule : tunnel_6in4_header_parser_top
`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 6in4 tunnel header parser.
// ----------------------------------------------------------------------------
// Frames are built from header descriptions and sent byte by byte. A bench
// copy of the parser works out the verdict of each frame as its last byte is
// accepted. Results are compared in order, field by field. A directed table
// covers every status code and the header corner cases. Random rounds follow,
// one link kind per round, with random idling on both sides, one long
// receiver hold-off and one round with no idling.
// ----------------------------------------------------------------------------
module testbench;

    import t6p_pkg::*;

    localparam int unsigned FRAME_CAP   = MAX_FRAME_BYTES_DEFAULT;
    localparam int          STALL_LIMIT = 4000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          RAND_BYTES  = 300;
    localparam int          RAND_FRAMES = 40;
    localparam int          DIRECTED_ROWS = 23;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [15:0] ETYPE_VLAN = 16'h8100;
    localparam logic [7:0]  PROTO_6IN4 = 8'd41;

    typedef enum logic [3:0] {
        LYR_START, LYR_ETH, LYR_VLAN, LYR_SLL, LYR_IPV4, LYR_IPV6, LYR_DONE, LYR_PAYLOAD
    } layer_t;

    // One frame: link header, VLAN tags, outer IP header, then tail bytes.
    // cut > 0 truncates the frame to that many bytes.
    typedef struct {
        logic [LINK_W-1:0]   link;
        logic [15:0]         sll_type;
        int                  vlans;
        logic [15:0]         etype;
        logic [7:0]          ip_lead;
        logic [7:0]          proto;
        int                  tail;
        int                  cut;
        bit                  fix;
        logic [STATUS_W-1:0] st;
        logic [POS_W-1:0]    off;
        logic [POS_W-1:0]    len;
    } frame_row_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [LINK_W-1:0]   cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata   = '0;
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // Bench copy of the parser state
    logic [LINK_W-1:0]   link_kind   = LINK_ETH;
    layer_t              parse_layer = LYR_START;
    logic [5:0]          layer_idx   = '0;
    int unsigned         byte_count  = 0;
    logic [15:0]         type_hi     = '0;
    int unsigned         ihl_bytes   = 0;
    logic [STATUS_W-1:0] verdict     = ST_OK;
    int unsigned         inner_start = 0;

    result_t    pending_verdicts[$];
    logic [7:0] frame_bytes[$];
    int         mismatches  = 0;
    int         idle_cycles = 0;
    int         hold_left   = 0;
    bit         hold_req    = 1'b0;
    bit         hold_taken  = 1'b0;
    bit         no_idle     = 1'b0;
    int         bytes_sent  = 0;
    int         frames_sent = 0;

    frame_row_t directed_rows [DIRECTED_ROWS] = '{
        '{LINK_ETH, 16'h0, 0, ETYPE_IPV4, 8'h45, PROTO_6IN4, 0, 0, 1, ST_OK, 16'd34, 16'd0},
        '{LINK_ETH, 16'h0, 0, ETYPE_IPV6, 8'h60, PROTO_6IN4, 10, 0, 1, ST_OK, 16'd54, 16'd10},
        '{LINK_ETH, 16'h0, 0, 16'h1234, 8'h45, PROTO_6IN4, 6, 0, 1, ST_ETYPE, 16'd0, 16'd0},
        '{LINK_ETH, 16'h0, 0, ETYPE_IPV4, 8'h45, PROTO_6IN4, 0, 5, 1, ST_TRUNC, 16'd0, 16'd0},
        '{LINK_ETH, 16'h0, 0, ETYPE_IPV4, 8'h55, PROTO_6IN4, 4, 0, 1, ST_NOT4, 16'd0, 16'd0},
        '{LINK_ETH, 16'h0, 0, ETYPE_IPV4, 8'h45, 8'd6, 4, 0, 1, ST_NOT6IN4, 16'd0, 16'd0},
        '{LINK_ETH, 16'h0, 0, ETYPE_IPV4, 8'h65, 8'd6, 0, 0, 1, ST_NOT4, 16'd0, 16'd0},
        '{LINK_ETH, 16'h0, 0, ETYPE_IPV6, 8'h40, PROTO_6IN4, 2, 0, 1, ST_NOT6, 16'd0, 16'd0},
        '{LINK_ETH, 16'h0, 0, ETYPE_IPV6, 8'h6F, 8'd17, 2, 0, 1, ST_NOT6IN4, 16'd0, 16'd0},
        '{LINK_ETH, 16'h0, 2, ETYPE_IPV4, 8'h45, PROTO_6IN4, 12, 0, 0, ST_OK, 16'd0, 16'd0},
        '{LINK_ETH, 16'h0, 1, ETYPE_IPV6, 8'h6A, PROTO_6IN4, 5, 0, 0, ST_OK, 16'd0, 16'd0},
        '{LINK_ETH, 16'h0, 0, ETYPE_IPV4, 8'h4F, PROTO_6IN4, 10, 0, 1, ST_TRUNC, 16'd0, 16'd0},
        '{LINK_ETH, 16'h0, 0, ETYPE_IPV4, 8'h40, PROTO_6IN4, 4, 0, 0, ST_OK, 16'd0, 16'd0},
        '{LINK_ETH, 16'h0, 0, ETYPE_IPV4, 8'h4F, PROTO_6IN4, 40, 0, 0, ST_OK, 16'd0, 16'd0},
        '{LINK_RAW, 16'h0, 0, ETYPE_IPV4, 8'h45, PROTO_6IN4, 3, 0, 1, ST_OK, 16'd20, 16'd3},
        '{LINK_RAW, 16'h0, 0, ETYPE_IPV4, 8'h60, PROTO_6IN4, 3, 0, 1, ST_NOT4, 16'd0, 16'd0},
        '{LINK_RAW, 16'h0, 0, ETYPE_IPV4, 8'h45, PROTO_6IN4, 0, 19, 1, ST_TRUNC, 16'd0, 16'd0},
        '{LINK_SLL, 16'h4, 0, ETYPE_IPV6, 8'h60, PROTO_6IN4, 8, 0, 0, ST_OK, 16'd0, 16'd0},
        '{LINK_SLL, 16'h5, 0, ETYPE_IPV4, 8'h45, PROTO_6IN4, 2, 0, 1, ST_SLLTYPE, 16'd0, 16'd0},
        '{LINK_SLL, 16'hFFFF, 0, ETYPE_IPV4, 8'h75, 8'd0, 0, 0, 1, ST_SLLTYPE, 16'd0, 16'd0},
        '{LINK_SLL, 16'h0, 0, ETYPE_VLAN, 8'h45, PROTO_6IN4, 0, 0, 1, ST_ETYPE, 16'd0, 16'd0},
        '{LINK_SLL, 16'h0, 0, ETYPE_IPV4, 8'h45, PROTO_6IN4, 0, 15, 1, ST_TRUNC, 16'd0, 16'd0},
        '{LINK_UNKN, 16'h0, 0, ETYPE_IPV4, 8'h45, PROTO_6IN4, 0, 1, 1, ST_LINK, 16'd0, 16'd0}
    };

    tunnel_6in4_header_parser_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void open_layer(input layer_t lyr);
        parse_layer = lyr;
        layer_idx   = '0;
        verdict     = ST_OK;
    endfunction

    function automatic void close_with(input logic [STATUS_W-1:0] code);
        parse_layer = LYR_DONE;
        verdict     = code;
    endfunction

    function automatic void route_etype(input logic [15:0] etype, input bit vlan_ok);
        if (etype == ETYPE_IPV4)
            open_layer(LYR_IPV4);
        else if (etype == ETYPE_IPV6)
            open_layer(LYR_IPV6);
        else if (etype == ETYPE_VLAN && vlan_ok)
            open_layer(LYR_VLAN);
        else
            close_with(ST_ETYPE);
    endfunction

    // Advance the parser copy by one accepted byte; returns 1 with the frame
    // verdict when the byte closes the frame.
    function automatic bit parse_frame_byte(input logic [7:0] b, input logic is_last,
                                            output result_t res);
        logic [15:0] word;
        int unsigned start_pos;
        bit          advance;
        advance = 1'b1;
        word    = type_hi | {8'h00, b};
        res     = '0;
        if (byte_count < FRAME_CAP && byte_count < 65535)
            byte_count++;
        if (parse_layer == LYR_START)
        begin
            case (link_kind)
                LINK_ETH: open_layer(LYR_ETH);
                LINK_RAW: open_layer(LYR_IPV4);
                LINK_SLL: open_layer(LYR_SLL);
                default:  close_with(ST_LINK);
            endcase
        end
        case (parse_layer)
            LYR_ETH:
            begin
                if (layer_idx == 12)
                    type_hi = {b, 8'h00};
                if (layer_idx == 13)
                begin
                    route_etype(word, 1'b1);
                    advance = 1'b0;
                end
            end
            LYR_VLAN:
            begin
                if (layer_idx == 2)
                    type_hi = {b, 8'h00};
                if (layer_idx == 3)
                begin
                    route_etype(word, 1'b1);
                    advance = 1'b0;
                end
            end
            LYR_SLL:
            begin
                if (layer_idx == 0 || layer_idx == 14)
                    type_hi = {b, 8'h00};
                if (layer_idx == 1 && word > 16'd4)
                    verdict = ST_SLLTYPE;
                if (layer_idx == 15)
                begin
                    advance = 1'b0;
                    if (verdict != ST_OK)
                        close_with(verdict);
                    else
                        route_etype(word, 1'b0);
                end
            end
            LYR_IPV4:
            begin
                if (layer_idx == 0)
                begin
                    ihl_bytes = 4 * b[3:0];
                    if (b[7:4] != 4'd4)
                        verdict = ST_NOT4;
                end
                if (layer_idx == 9 && b != PROTO_6IN4 && verdict == ST_OK)
                    verdict = ST_NOT6IN4;
                if (layer_idx == 19)
                begin
                    advance = 1'b0;
                    if (verdict != ST_OK)
                        close_with(verdict);
                    else
                    begin
                        start_pos   = (byte_count >= 20 ? byte_count - 20 : 0) + ihl_bytes;
                        inner_start = start_pos > 65535 ? 65535 : start_pos;
                        parse_layer = LYR_PAYLOAD;
                    end
                end
            end
            LYR_IPV6:
            begin
                if (layer_idx == 0 && b[7:4] != 4'd6)
                    verdict = ST_NOT6;
                if (layer_idx == 6 && b != PROTO_6IN4 && verdict == ST_OK)
                    verdict = ST_NOT6IN4;
                if (layer_idx == 39)
                begin
                    advance = 1'b0;
                    if (verdict != ST_OK)
                        close_with(verdict);
                    else
                    begin
                        inner_start = byte_count & 32'hFFFF;
                        parse_layer = LYR_PAYLOAD;
                    end
                end
            end
            default: advance = 1'b0;
        endcase
        if (advance)
            layer_idx = layer_idx + 6'd1;
        if (!is_last)
            return 1'b0;

        if (parse_layer == LYR_DONE)
            res.status = verdict;
        else if (parse_layer == LYR_PAYLOAD && byte_count >= inner_start)
        begin
            res.status         = ST_OK;
            res.payload_offset = POS_W'(inner_start);
            res.payload_length = POS_W'(byte_count - inner_start);
        end
        else
            res.status = ST_TRUNC;

        // next byte starts a new frame
        parse_layer = LYR_START;
        layer_idx   = '0;
        byte_count  = 0;
        type_hi     = '0;
        ihl_bytes   = 0;
        verdict     = ST_OK;
        inner_start = 0;
        return 1'b1;
    endfunction

    function automatic void assemble_frame(input frame_row_t row);
        int          hdr_len;
        int          proto_pos;
        logic [15:0] next_type;
        frame_bytes.delete();
        if (row.link == LINK_SLL)
        begin
            frame_bytes.push_back(row.sll_type[15:8]);
            frame_bytes.push_back(row.sll_type[7:0]);
            repeat (12) frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(row.etype[15:8]);
            frame_bytes.push_back(row.etype[7:0]);
        end
        else if (row.link != LINK_RAW)
        begin
            repeat (12) frame_bytes.push_back(8'($urandom));
            for (int i = 0; i <= row.vlans; i++)
            begin
                next_type = (i < row.vlans) ? ETYPE_VLAN : row.etype;
                if (i > 0)
                    repeat (2) frame_bytes.push_back(8'($urandom));
                frame_bytes.push_back(next_type[15:8]);
                frame_bytes.push_back(next_type[7:0]);
            end
        end
        hdr_len   = (row.link != LINK_RAW && row.etype == ETYPE_IPV6) ? 40 : 20;
        proto_pos = (hdr_len == 40) ? 6 : 9;
        frame_bytes.push_back(row.ip_lead);
        for (int k = 1; k < hdr_len; k++)
            frame_bytes.push_back(k == proto_pos ? row.proto : 8'($urandom));
        repeat (row.tail) frame_bytes.push_back(8'($urandom));
        if (row.cut > 0)
        begin
            while (frame_bytes.size() > row.cut)
                void'(frame_bytes.pop_back());
        end
    endfunction

    function automatic frame_row_t random_row(input logic [LINK_W-1:0] lk);
        frame_row_t row;
        int         pick;
        logic [3:0] ihl;
        row      = '{default: 0};
        row.link = lk;
        row.sll_type = ($urandom_range(99) < 85) ? 16'($urandom_range(4)) : 16'($urandom);
        row.vlans    = ($urandom_range(99) < 70) ? 0 : $urandom_range(1, 3);
        pick = $urandom_range(99);
        if (lk == LINK_RAW || pick < 50)
            row.etype = ETYPE_IPV4;
        else if (pick < 85)
            row.etype = ETYPE_IPV6;
        else if (pick < 92)
            row.etype = ETYPE_VLAN;
        else
            row.etype = 16'($urandom);
        ihl = ($urandom_range(99) < 75) ? 4'd5 : 4'($urandom);
        if ($urandom_range(99) < 85)
            row.ip_lead = (row.etype == ETYPE_IPV6) ? {4'h6, 4'($urandom)} : {4'h4, ihl};
        else
            row.ip_lead = 8'($urandom);
        row.proto = ($urandom_range(99) < 85) ? PROTO_6IN4 : 8'($urandom);
        row.tail  = $urandom_range(0, 24);
        row.cut   = ($urandom_range(99) < 20) ? $urandom_range(1, 60) : 0;
        return row;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic is_last, input bit use_typed,
                             input result_t typed);
        result_t predicted;
        if (!no_idle && $urandom_range(99) < 23)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        if (parse_frame_byte(b, is_last, predicted))
            pending_verdicts.push_back(use_typed ? typed : predicted);
    endtask

    task automatic send_frame(input frame_row_t row, input bit scramble);
        result_t typed;
        int      n;
        assemble_frame(row);
        if (scramble)
        begin
            foreach (frame_bytes[i])
                frame_bytes[i] = 8'($urandom);
        end
        typed.status         = row.st;
        typed.payload_offset = row.off;
        typed.payload_length = row.len;
        n = frame_bytes.size();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == n - 1, row.fix, typed);
        bytes_sent  += n;
        frames_sent += 1;
    endtask

    // Hold the input until every verdict is out, then allow for the pipeline.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_link_kind(input logic [LINK_W-1:0] lk);
        cfg_valid <= 1'b1;
        cfg_data  <= lk;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        link_kind = lk;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic report_mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
            m_tready <= no_idle || ($urandom_range(99) >= 23);
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            got = result_t'(m_tdata[RES_BITS-1:0]);
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d off %0d len %0d",
                         $time, got.status, got.payload_offset, got.payload_length);
                mismatches++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", want.status, got.status);
                if (got.payload_offset !== want.payload_offset)
                    report_mismatch("payload_offset", want.payload_offset, got.payload_offset);
                if (got.payload_length !== want.payload_length)
                    report_mismatch("payload_length", want.payload_length, got.payload_length);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_verdicts.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int                prog_link;
        int                pick;
        int                round;
        logic [LINK_W-1:0] lk;
        frame_row_t        row;
        prog_link = -1;
        round     = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (int'(directed_rows[r].link) != prog_link)
            begin
                drain_results();
                write_link_kind(directed_rows[r].link);
                prog_link = directed_rows[r].link;
            end
            send_frame(directed_rows[r], 1'b0);
        end

        bytes_sent  = 0;
        frames_sent = 0;
        while (round < 4 || bytes_sent < RAND_BYTES || frames_sent < RAND_FRAMES)
        begin
            drain_results();
            pick = $urandom_range(99);
            lk = pick < 40 ? LINK_ETH : pick < 60 ? LINK_RAW : pick < 90 ? LINK_SLL : LINK_UNKN;
            write_link_kind(lk);
            no_idle = (round == 3);
            if (round == 1)
            begin
                // stall the output and keep short frames coming until the
                // input backs up
                hold_req = 1'b1;
                repeat (30)
                begin
                    row     = random_row(lk);
                    row.cut = $urandom_range(1, 2);
                    send_frame(row, 1'b0);
                end
            end
            repeat (no_idle ? 5 : $urandom_range(1, 2))
                send_frame(random_row(lk), $urandom_range(99) < 10);
            round++;
        end

        drain_results();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/t6p_pkg.sv
hw/rtl/t6p_in_stage.sv
hw/rtl/t6p_parse.sv
hw/rtl/t6p_out_stage.sv
hw/rtl/tunnel_6in4_header_parser_top.sv
tb/testbench.sv
